// ===== rtl/bltw_pkg.sv =====
// Shared types, sizes and register codes of the bilinear trapezoid warp.
package bltw_pkg;

   localparam int IMG_WIDTH   = 256;
   localparam int IMG_HEIGHT  = 256;
   localparam int STORE_DEPTH = IMG_WIDTH * IMG_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int X_W         = $clog2(IMG_WIDTH);
   localparam int Y_W         = $clog2(IMG_HEIGHT);

   localparam int COORD_W     = 8;
   localparam int CHAN_W      = 16;
   localparam int PIX_W       = 3 * CHAN_W;

   localparam int NUM_REGS    = 8;
   localparam int REG_IDX_W   = $clog2(NUM_REGS);
   localparam int COEF_W      = 32;
   localparam int FRAC_W      = 16;
   localparam int P_LIN_W     = COEF_W + COORD_W + 1;
   localparam int P_CROSS_W   = COEF_W + 2 * COORD_W + 1;
   localparam int SUM_W       = COEF_W + 2 * COORD_W;
   localparam int INT_W       = SUM_W - FRAC_W;

   localparam logic signed [COEF_W-1:0] ONE_Q16 = COEF_W'(1 << FRAC_W);
   localparam logic signed [SUM_W-1:0]  NEG_ONE_Q16 = -SUM_W'(1 << FRAC_W);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_COEF_X_COL,
      REG_COEF_X_ROW,
      REG_COEF_X_CROSS,
      REG_OFFSET_X,
      REG_COEF_Y_COL,
      REG_COEF_Y_ROW,
      REG_COEF_Y_CROSS,
      REG_OFFSET_Y
   } reg_index_type;

   typedef struct packed {
      op_type              op;
      logic                blank;
      logic [ADDR_W-1:0]   addr;
      logic [PIX_W-1:0]    data;
   } cmd_type;

   function automatic logic [ADDR_W-1:0] pixel_addr(logic [ADDR_W-1:0] y,
                                                    logic [ADDR_W-1:0] x);
      pixel_addr = ADDR_W'(y * IMG_WIDTH + x);
   endfunction

endpackage

// ===== rtl/bltw_stream_if.sv =====
// Request and response channel interfaces of the warp block.
interface bltw_req_if import bltw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                cmd;
   logic [COORD_W-1:0]  pix_row;
   logic [COORD_W-1:0]  pix_col;
   logic [CHAN_W-1:0]   in_chan0;
   logic [CHAN_W-1:0]   in_chan1;
   logic [CHAN_W-1:0]   in_chan2;

   modport source (output valid, cmd, pix_row, pix_col, in_chan0, in_chan1, in_chan2,
                   input ready);
   modport sink   (input valid, cmd, pix_row, pix_col, in_chan0, in_chan1, in_chan2,
                   output ready);
endinterface

interface bltw_rsp_if import bltw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CHAN_W-1:0]   out_chan0;
   logic [CHAN_W-1:0]   out_chan1;
   logic [CHAN_W-1:0]   out_chan2;
   logic                blanked;

   modport source (output valid, out_chan0, out_chan1, out_chan2, blanked, input ready);
   modport sink   (input valid, out_chan0, out_chan1, out_chan2, blanked, output ready);
endinterface

// ===== rtl/bltw_front.sv =====
// Front end: coefficient registers, request intake and coordinate mapping pipeline.
module bltw_front import bltw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bltw_req_if.sink              req,
   input  logic                  csr_we,
   input  logic [REG_IDX_W-1:0]  csr_index,
   input  logic [COEF_W-1:0]     csr_wdata,
   input  logic                  q_full,
   output logic                  q_push,
   output cmd_type               q_push_cmd
);

   logic signed [COEF_W-1:0] coef_ff [NUM_REGS];

   logic                   advance;
   logic                   wr_inside;
   op_type                 req_op;

   logic                   s1_v_ff, s1_v_in;
   op_type                 s1_op_ff;
   logic [COORD_W-1:0]     s1_row_ff, s1_col_ff;
   logic [2*COORD_W-1:0]   s1_ji_ff;
   logic [ADDR_W-1:0]      s1_addr_ff;
   logic [PIX_W-1:0]       s1_data_ff;

   logic                   s2_v_ff;
   op_type                 s2_op_ff;
   logic [ADDR_W-1:0]      s2_addr_ff;
   logic [PIX_W-1:0]       s2_data_ff;
   logic signed [P_LIN_W-1:0]   s2_px1_ff, s2_px2_ff, s2_py1_ff, s2_py2_ff;
   logic signed [P_CROSS_W-1:0] s2_px3_ff, s2_py3_ff;

   logic                   s3_v_ff;
   op_type                 s3_op_ff;
   logic [ADDR_W-1:0]      s3_addr_ff;
   logic [PIX_W-1:0]       s3_data_ff;
   logic signed [SUM_W-1:0] s3_sxa_ff, s3_sxb_ff, s3_sya_ff, s3_syb_ff;

   logic                   s4_v_ff;
   op_type                 s4_op_ff;
   logic [ADDR_W-1:0]      s4_addr_ff;
   logic [PIX_W-1:0]       s4_data_ff;
   logic signed [SUM_W-1:0] s4_accx_ff, s4_accy_ff;

   logic signed [COORD_W:0]     j_s, i_s;
   logic signed [2*COORD_W:0]   ji_s;
   logic                   in_x, in_y;
   logic [X_W-1:0]         x_idx;
   logic [Y_W-1:0]         y_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_REGS; k++) begin
            coef_ff[k] <= '0;
         end
         coef_ff[REG_COEF_X_COL] <= ONE_Q16;
         coef_ff[REG_COEF_Y_ROW] <= ONE_Q16;
      end else if (csr_we) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   assign advance = !s4_v_ff || !q_full;
   assign req.ready = advance;
   assign req_op = op_type'(req.cmd);
   assign wr_inside = (32'(req.pix_row) < IMG_HEIGHT) && (32'(req.pix_col) < IMG_WIDTH);
   // drop writes that fall outside the frame
   assign s1_v_in = req.valid && ((req_op == OP_READ) || wr_inside);

   assign j_s  = $signed({1'b0, s1_col_ff});
   assign i_s  = $signed({1'b0, s1_row_ff});
   assign ji_s = $signed({1'b0, s1_ji_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else if (advance) begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff   <= req_op;
         s1_row_ff  <= req.pix_row;
         s1_col_ff  <= req.pix_col;
         s1_ji_ff   <= (2*COORD_W)'(req.pix_row) * (2*COORD_W)'(req.pix_col);
         s1_addr_ff <= pixel_addr(ADDR_W'(req.pix_row), ADDR_W'(req.pix_col));
         s1_data_ff <= {req.in_chan2, req.in_chan1, req.in_chan0};

         s2_op_ff   <= s1_op_ff;
         s2_addr_ff <= s1_addr_ff;
         s2_data_ff <= s1_data_ff;
         s2_px1_ff  <= P_LIN_W'(coef_ff[REG_COEF_X_COL]) * P_LIN_W'(j_s);
         s2_px2_ff  <= P_LIN_W'(coef_ff[REG_COEF_X_ROW]) * P_LIN_W'(i_s);
         s2_px3_ff  <= P_CROSS_W'(coef_ff[REG_COEF_X_CROSS]) * P_CROSS_W'(ji_s);
         s2_py1_ff  <= P_LIN_W'(coef_ff[REG_COEF_Y_COL]) * P_LIN_W'(j_s);
         s2_py2_ff  <= P_LIN_W'(coef_ff[REG_COEF_Y_ROW]) * P_LIN_W'(i_s);
         s2_py3_ff  <= P_CROSS_W'(coef_ff[REG_COEF_Y_CROSS]) * P_CROSS_W'(ji_s);

         s3_op_ff   <= s2_op_ff;
         s3_addr_ff <= s2_addr_ff;
         s3_data_ff <= s2_data_ff;
         s3_sxa_ff  <= SUM_W'(s2_px1_ff) + SUM_W'(s2_px2_ff);
         s3_sxb_ff  <= SUM_W'(s2_px3_ff) + SUM_W'(coef_ff[REG_OFFSET_X]);
         s3_sya_ff  <= SUM_W'(s2_py1_ff) + SUM_W'(s2_py2_ff);
         s3_syb_ff  <= SUM_W'(s2_py3_ff) + SUM_W'(coef_ff[REG_OFFSET_Y]);

         s4_op_ff   <= s3_op_ff;
         s4_addr_ff <= s3_addr_ff;
         s4_data_ff <= s3_data_ff;
         s4_accx_ff <= s3_sxa_ff + s3_sxb_ff;
         s4_accy_ff <= s3_sya_ff + s3_syb_ff;
      end
   end

   // truncation toward zero: values in (-1, 0) land on index zero
   always_comb begin
      in_x = (s4_accx_ff > NEG_ONE_Q16) &&
             ($signed(s4_accx_ff[SUM_W-1:FRAC_W]) < $signed(INT_W'(IMG_WIDTH)));
      in_y = (s4_accy_ff > NEG_ONE_Q16) &&
             ($signed(s4_accy_ff[SUM_W-1:FRAC_W]) < $signed(INT_W'(IMG_HEIGHT)));
      x_idx = s4_accx_ff[SUM_W-1] ? '0 : s4_accx_ff[FRAC_W +: X_W];
      y_idx = s4_accy_ff[SUM_W-1] ? '0 : s4_accy_ff[FRAC_W +: Y_W];

      q_push_cmd.op    = s4_op_ff;
      q_push_cmd.data  = s4_data_ff;
      q_push_cmd.blank = (s4_op_ff == OP_READ) && !(in_x && in_y);
      q_push_cmd.addr  = (s4_op_ff == OP_READ) ?
                         pixel_addr(ADDR_W'(y_idx), ADDR_W'(x_idx)) : s4_addr_ff;
   end

   assign q_push = s4_v_ff && !q_full;

endmodule

// ===== rtl/bltw_queue.sv =====
// Short command queue between the mapping front end and the frame store back end.
module bltw_queue import bltw_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cmd_type  push_cmd,
   output logic     full,
   input  logic     pop,
   output cmd_type  pop_cmd,
   output logic     empty
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/bltw_back.sv =====
// Back end: frame store, registered read and response output stage.
module bltw_back import bltw_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   input  cmd_type  q_pop_cmd,
   output logic     q_pop,
   bltw_rsp_if.source rsp
);

   logic [PIX_W-1:0]    mem [STORE_DEPTH];
   logic [PIX_W-1:0]    rd_q_ff;

   logic                r_v_ff, r_v_in;
   logic                r_blank_ff;
   logic                o_v_ff;
   logic                o_blank_ff;
   logic [PIX_W-1:0]    o_data_ff;

   logic                o_free, r_free;
   logic                is_read, mem_wr, mem_rd;

   assign o_free  = !o_v_ff || rsp.ready;
   assign r_free  = !r_v_ff || o_free;
   assign is_read = (q_pop_cmd.op == OP_READ);
   assign q_pop   = !q_empty && (!is_read || r_free);
   assign mem_wr  = q_pop && !is_read;
   assign mem_rd  = q_pop && is_read && !q_pop_cmd.blank;

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[q_pop_cmd.addr] <= q_pop_cmd.data;
      end
      if (mem_rd) begin
         rd_q_ff <= mem[q_pop_cmd.addr];
      end
   end

   always_comb begin
      r_v_in = r_v_ff;
      if (q_pop && is_read) begin
         r_v_in = 1'b1;
      end else if (o_free) begin
         r_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         r_v_ff <= r_v_in;
         if (o_free) begin
            o_v_ff <= r_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && is_read) begin
         r_blank_ff <= q_pop_cmd.blank;
      end
      if (o_free) begin
         o_blank_ff <= r_blank_ff;
         o_data_ff  <= r_blank_ff ? '0 : rd_q_ff;
      end
   end

   assign rsp.valid     = o_v_ff;
   assign rsp.out_chan0 = o_data_ff[0*CHAN_W +: CHAN_W];
   assign rsp.out_chan1 = o_data_ff[1*CHAN_W +: CHAN_W];
   assign rsp.out_chan2 = o_data_ff[2*CHAN_W +: CHAN_W];
   assign rsp.blanked   = o_blank_ff;

endmodule

// ===== rtl/bilinear_trapezoid_warp.sv =====
// Top level of the bilinear trapezoid warp: front end, command queue and frame store.
//
// The req channel carries two kinds of transfer. cmd 0 stores a three-channel pixel at
// (pix_row, pix_col); writes outside the frame are dropped and give no response. cmd 1
// asks for output pixel (pix_row, pix_col): the eight Q16.16 csr registers map it to a
// source position, truncated toward zero, and the rsp channel returns the stored pixel
// or a zero pixel with blanked set when the position falls outside the frame.
// A request passes through four mapping stages, one queue slot, the frame store read and
// the output register before its response appears. One transfer per cycle is sustained
// in both directions while rsp is ready; the single port of the frame store, taking one
// write or one read per cycle, sets that figure.
// When rsp is stalled the output and read stages hold, the four-entry queue fills, and
// req.ready drops once the last mapping stage can no longer drain into the queue.
// Reset clears the pipeline, queue and output stage and loads the identity map into the
// csr registers. The frame store is not cleared; read only locations already written.
// Write csr registers only while the block is idle.
module bilinear_trapezoid_warp import bltw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bltw_req_if.sink              req,
   bltw_rsp_if.source            rsp,
   input  logic                  csr_we,
   input  logic [REG_IDX_W-1:0]  csr_index,
   input  logic [COEF_W-1:0]     csr_wdata
);

   logic     q_push, q_pop, q_full, q_empty;
   cmd_type  q_push_cmd, q_pop_cmd;

   bltw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_push_cmd (q_push_cmd)
   );

   bltw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (q_pop_cmd),
      .empty    (q_empty)
   );

   bltw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop_cmd (q_pop_cmd),
      .q_pop     (q_pop),
      .rsp       (rsp)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("queue pushed while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_empty))
      else $error("queue popped while empty");

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("response valid right after reset");

   a_stall_blocks_intake: assert property (@(posedge clock) disable iff (reset)
      (q_full && !q_pop) |=> q_full)
      else $error("queue drained without a pop");

endmodule

// ===== tb/sv/bilinear_trapezoid_warp_test.sv =====
// Self-checking testbench of the bilinear trapezoid warp: frame writes, warped reads, map sweeps.
`timescale 1ns / 1ps

module bilinear_trapezoid_warp_test import bltw_pkg::*; ();

   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 12;
   localparam int LONG_HOLD = 120;
   localparam int LONG_HOLD_AFTER = 300;

   typedef struct {
      op_type              op;
      logic [COORD_W-1:0]  row;
      logic [COORD_W-1:0]  col;
      logic [CHAN_W-1:0]   ch0;
      logic [CHAN_W-1:0]   ch1;
      logic [CHAN_W-1:0]   ch2;
   } warp_item_type;

   typedef struct packed {
      logic [CHAN_W-1:0]   chan0;
      logic [CHAN_W-1:0]   chan1;
      logic [CHAN_W-1:0]   chan2;
      logic                blanked;
   } warp_pixel_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [REG_IDX_W-1:0]  csr_index;
   logic [COEF_W-1:0]     csr_wdata;

   bltw_req_if req_bus ();
   bltw_rsp_if rsp_bus ();

   bilinear_trapezoid_warp DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   warp_item_type       pending_items[$];
   warp_pixel_type      expected_pixels[$];
   warp_item_type       current_item;
   logic [PIX_W-1:0]    frame_model [STORE_DEPTH];
   bit                  frame_planned [STORE_DEPTH];
   logic [COEF_W-1:0]   warp_coef [NUM_REGS];
   logic [COEF_W-1:0]   next_map [NUM_REGS];

   int   items_queued = 0;
   int   items_accepted = 0;
   int   pixels_checked = 0;
   int   error_count = 0;
   int   quiet_cycles = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   send_gap = 0;
   int   hold_left = 0;
   bit   req_fired = 1'b0;
   bit   long_hold_done = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint map_axis(logic [COEF_W-1:0] c_col, logic [COEF_W-1:0] c_row,
                                       logic [COEF_W-1:0] c_cross, logic [COEF_W-1:0] c_off,
                                       logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
      longint j, i, acc;
      j = longint'(col);
      i = longint'(row);
      acc = longint'(signed'(c_col)) * j + longint'(signed'(c_row)) * i
          + longint'(signed'(c_cross)) * (j * i) + longint'(signed'(c_off));
      return acc / (longint'(1) << FRAC_W);
   endfunction

   function automatic longint source_x(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
      return map_axis(warp_coef[REG_COEF_X_COL], warp_coef[REG_COEF_X_ROW],
                      warp_coef[REG_COEF_X_CROSS], warp_coef[REG_OFFSET_X], row, col);
   endfunction

   function automatic longint source_y(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
      return map_axis(warp_coef[REG_COEF_Y_COL], warp_coef[REG_COEF_Y_ROW],
                      warp_coef[REG_COEF_Y_CROSS], warp_coef[REG_OFFSET_Y], row, col);
   endfunction

   function automatic bit in_frame(longint sx, longint sy);
      return sx >= 0 && sx < IMG_WIDTH && sy >= 0 && sy < IMG_HEIGHT;
   endfunction

   task automatic forecast_pixel(warp_item_type it);
      longint         sx, sy;
      warp_pixel_type px;
      if (it.op == OP_WRITE) begin
         if (it.row < IMG_HEIGHT && it.col < IMG_WIDTH)
            frame_model[int'(it.row) * IMG_WIDTH + int'(it.col)] = {it.ch0, it.ch1, it.ch2};
      end else begin
         sx = source_x(it.row, it.col);
         sy = source_y(it.row, it.col);
         px = '0;
         if (in_frame(sx, sy))
            {px.chan0, px.chan1, px.chan2} = frame_model[int'(sy) * IMG_WIDTH + int'(sx)];
         else
            px.blanked = 1'b1;
         expected_pixels.push_back(px);
      end
   endtask

   function automatic logic [CHAN_W-1:0] rand_chan();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return COORD_W'($urandom_range(0, IMG_WIDTH - 1));
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] span(int unsigned r);
      return COEF_W'($urandom_range(0, 2 * r) - r);
   endfunction

   function automatic int pick_pct();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 15;
         default: return 40;
      endcase
   endfunction

   task automatic queue_item(op_type op, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                             logic [CHAN_W-1:0] c0, logic [CHAN_W-1:0] c1,
                             logic [CHAN_W-1:0] c2);
      warp_item_type it;
      it.op = op;
      it.row = row;
      it.col = col;
      it.ch0 = c0;
      it.ch1 = c1;
      it.ch2 = c2;
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic plan_write(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                             logic [CHAN_W-1:0] c0, logic [CHAN_W-1:0] c1,
                             logic [CHAN_W-1:0] c2);
      frame_planned[int'(row) * IMG_WIDTH + int'(col)] = 1'b1;
      queue_item(OP_WRITE, row, col, c0, c1, c2);
   endtask

   // fill the source pixel first when the request lands on a location never written
   task automatic plan_request(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
      longint sx, sy;
      sx = source_x(row, col);
      sy = source_y(row, col);
      if (in_frame(sx, sy) && !frame_planned[int'(sy) * IMG_WIDTH + int'(sx)])
         plan_write(COORD_W'(sy), COORD_W'(sx), rand_chan(), rand_chan(), rand_chan());
      queue_item(OP_READ, row, col, rand_chan(), rand_chan(), rand_chan());
   endtask

   task automatic set_identity();
      foreach (next_map[k]) next_map[k] = '0;
      next_map[REG_COEF_X_COL] = ONE_Q16;
      next_map[REG_COEF_Y_ROW] = ONE_Q16;
   endtask

   task automatic set_uniform(logic [COEF_W-1:0] v);
      foreach (next_map[k]) next_map[k] = v;
   endtask

   task automatic set_trapezoid();
      next_map[REG_COEF_X_COL]   = ONE_Q16 + span(32768);
      next_map[REG_COEF_X_ROW]   = span(16384);
      next_map[REG_COEF_X_CROSS] = span(96);
      next_map[REG_OFFSET_X]     = span(48 << FRAC_W);
      next_map[REG_COEF_Y_COL]   = span(16384);
      next_map[REG_COEF_Y_ROW]   = ONE_Q16 + span(32768);
      next_map[REG_COEF_Y_CROSS] = span(96);
      next_map[REG_OFFSET_Y]     = span(48 << FRAC_W);
   endtask

   task automatic set_scramble();
      foreach (next_map[k]) next_map[k] = COEF_W'($urandom);
   endtask

   task automatic apply_map();
      for (int k = 0; k < NUM_REGS; k++) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_index <= reg_index_type'(k);
         csr_wdata <= next_map[k];
         warp_coef[k] = next_map[k];
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // hold until every item is taken and answered, then let trailing writes settle
   task automatic drain();
      while (items_accepted != items_queued || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(int n, int send_pct, int recv_pct);
      int stop_at;
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      stop_at = items_queued + n;
      while (items_queued < stop_at) begin
         if ($urandom_range(0, 3) == 0)
            plan_write(pick_coord(), pick_coord(), rand_chan(), rand_chan(), rand_chan());
         else
            plan_request(pick_coord(), pick_coord());
      end
      drain();
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.cmd <= OP_WRITE;
         req_bus.pix_row <= '0;
         req_bus.pix_col <= '0;
         req_bus.in_chan0 <= '0;
         req_bus.in_chan1 <= '0;
         req_bus.in_chan2 <= '0;
      end else if (!req_bus.valid || req_fired) begin
         req_fired = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            send_gap = $urandom_range(0, 4);
            req_bus.valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            current_item = pending_items.pop_front();
            req_bus.cmd <= current_item.op;
            req_bus.pix_row <= current_item.row;
            req_bus.pix_col <= current_item.col;
            req_bus.in_chan0 <= current_item.ch0;
            req_bus.in_chan1 <= current_item.ch1;
            req_bus.in_chan2 <= current_item.ch2;
            req_bus.valid <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!long_hold_done && pixels_checked >= LONG_HOLD_AFTER) begin
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_bus.ready <= 1'b0;
      end else if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct) begin
         hold_left = $urandom_range(0, 4);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // monitor: check the response before predicting, so a fresh expectation is never matched
   always @(posedge clock) begin
      if (!reset) begin
         bit             moved;
         warp_pixel_type got, want;
         moved = 1'b0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            got = {rsp_bus.out_chan0, rsp_bus.out_chan1, rsp_bus.out_chan2, rsp_bus.blanked};
            if (expected_pixels.size() == 0) begin
               error_count++;
               $display("%0t: unexpected transfer: got %h %h %h blanked %b", $time,
                        got.chan0, got.chan1, got.chan2, got.blanked);
            end else begin
               want = expected_pixels.pop_front();
               if (got.chan0 !== want.chan0 || got.chan1 !== want.chan1 ||
                   got.chan2 !== want.chan2 || got.blanked !== want.blanked) begin
                  error_count++;
                  $display("%0t: pixel mismatch: expected %h %h %h blanked %b, got %h %h %h blanked %b",
                           $time, want.chan0, want.chan1, want.chan2, want.blanked,
                           got.chan0, got.chan1, got.chan2, got.blanked);
               end
            end
            pixels_checked++;
         end
         if (req_bus.valid && req_bus.ready) begin
            moved = 1'b1;
            forecast_pixel(current_item);
            items_accepted++;
            req_fired = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   initial begin
      do @(negedge clock); while (quiet_cycles < STALL_LIMIT);
      $display("** bilinear_trapezoid_warp: FAILED **");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = REG_COEF_X_COL;
      csr_wdata = '0;
      set_identity();
      foreach (warp_coef[k]) warp_coef[k] = next_map[k];
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // identity map after reset: corners, extreme samples, overwrite
      plan_write('0, '0, '0, '0, '0);
      plan_write('1, '1, '1, '1, '1);
      plan_write('0, '1, 16'h8000, 16'h7FFF, 16'h0001);
      plan_write('1, '0, 16'h5555, 16'hAAAA, 16'h00FF);
      plan_request('0, '0);
      plan_request('1, '1);
      plan_request('0, '1);
      plan_request('1, '0);
      plan_write('0, '0, '1, '0, '1);
      plan_request('0, '0);
      drain();

      // half-pixel negative offset truncates back into the frame
      set_identity();
      next_map[REG_OFFSET_X] = -(ONE_Q16 >>> 1);
      next_map[REG_OFFSET_Y] = -(ONE_Q16 >>> 1);
      apply_map();
      plan_request('0, '0);
      plan_request(8'd1, 8'd1);
      plan_request('0, '1);
      drain();

      // full-pixel negative offset leaves the frame at the origin
      set_identity();
      next_map[REG_OFFSET_X] = -ONE_Q16;
      next_map[REG_OFFSET_Y] = -ONE_Q16;
      apply_map();
      plan_request('0, '0);
      plan_request('1, '1);
      drain();

      set_uniform({1'b1, {(COEF_W - 1){1'b0}}});
      apply_map();
      plan_request('0, '0);
      plan_request('1, '1);
      drain();

      set_uniform({1'b0, {(COEF_W - 1){1'b1}}});
      apply_map();
      plan_request('0, '0);
      plan_request(8'd1, 8'd1);
      drain();

      set_uniform('0);
      apply_map();
      plan_request(8'd200, 8'd37);
      drain();

      for (int p = 0; p < 10; p++) begin
         if (p == 3 || p == 7) begin
            set_scramble();
            apply_map();
            run_phase(60, pick_pct(), pick_pct());
         end else begin
            set_trapezoid();
            apply_map();
            run_phase(150, pick_pct(), pick_pct());
         end
      end

      set_trapezoid();
      apply_map();
      run_phase(180, 0, 0);

      if (error_count == 0 && expected_pixels.size() == 0)
         $display("** bilinear_trapezoid_warp: PASSED **");
      else
         $display("** bilinear_trapezoid_warp: FAILED **");
      $finish;
   end

endmodule
